// File: rtl/gbc_pkg.sv
// Shared constants, types and angle table for the bearing pipeline.
`timescale 1ns / 1ps
`default_nettype none
package gbc_pkg;
  localparam int CORDIC_STAGES = 24;
  localparam int NSTAGES = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int SIDX_W = (NSTAGES > 1) ? $clog2(NSTAGES) : 1;

  localparam int CW = 34;   // cosine CORDIC x/y width, Q2.30 plus growth
  localparam int AW = 34;   // residual angle width
  localparam int VW = 67;   // vectoring x/y width
  localparam int ZW = 32;   // binary angle, modulo one turn
  localparam int HW = 25;

  localparam logic [CW-1:0] INV_GAIN_Q30 = CW'(652032874);
  localparam logic [HW-1:0] HDG_0   = HW'(0);
  localparam logic [HW-1:0] HDG_90  = HW'(5898240);
  localparam logic [HW-1:0] HDG_180 = HW'(11796480);
  localparam logic [HW-1:0] HDG_270 = HW'(17694720);
  localparam logic [HW-1:0] HDG_360 = HW'(23592960);

  typedef enum logic [1:0] {
    MODE_FIXED,   // heading decided up front
    MODE_CORDIC
  } mode_t;

  // Sideband that rides along the chain with each item.
  typedef struct packed {
    logic              vld;
    mode_t             mode;
    logic [HW-1:0]     fixed_hdg;
    logic signed [32:0] dlon;
    logic signed [31:0] dlat;
    logic              neg;
  } side_t;

  function automatic logic [31:0] arc(input logic [5:0] i);
    logic [31:0] t [32];
    t = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
          32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
          32'd2670163, 32'd1335087, 32'd667544, 32'd333772, 32'd166886,
          32'd83443, 32'd41722, 32'd20861, 32'd10430, 32'd5215, 32'd2608,
          32'd1304, 32'd652, 32'd326, 32'd163, 32'd81, 32'd41, 32'd20,
          32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};
    return t[i[4:0]];
  endfunction
endpackage
`default_nettype wire

// File: rtl/gps_bearing_calculator.sv
// Top level: prep stages, cosine cell chain, multiply, atan2 cell chain, scaling.
//  channel | ports                                   | dir
//  in      | in_valid in_ready in_first_lat/lon ...  | sink
//  out     | out_valid out_ready out_heading         | source
// One item enters per cycle whenever the chain is not stalled.
// The whole chain advances together; it stalls only when the output
// register is full and out_ready is low.
// Reset clears the valid bits of every stage; payload is not reset.
`timescale 1ns / 1ps
`default_nettype none
module gps_bearing_calculator import gbc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [30:0] in_first_lat,
  input  wire logic signed [31:0] in_first_lon,
  input  wire logic signed [30:0] in_second_lat,
  input  wire logic signed [31:0] in_second_lon,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [HW-1:0]           out_heading
);
  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // stage 0: classify, differences, |lat|
  side_t s0_r;
  logic [30:0] alat_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s0_r.vld <= 1'b0;
    else if (en) s0_r.vld <= in_valid;
    if (en) begin
      s0_r.dlat <= 32'(in_second_lat) - 32'(in_first_lat);
      s0_r.dlon <= 33'(in_second_lon) - 33'(in_first_lon);
      alat_r <= in_first_lat[30] ? 31'(-33'(in_first_lat)) : in_first_lat;
      s0_r.neg <= 1'b0;
      if (in_first_lat == in_second_lat) begin
        s0_r.mode <= MODE_FIXED;
        if (in_second_lon > in_first_lon) s0_r.fixed_hdg <= HDG_90;
        else if (in_second_lon < in_first_lon) s0_r.fixed_hdg <= HDG_270;
        else s0_r.fixed_hdg <= HDG_0;
      end else if (in_first_lon == in_second_lon) begin
        s0_r.mode <= MODE_FIXED;
        s0_r.fixed_hdg <= (in_second_lat > in_first_lat) ? HDG_0 : HDG_180;
      end else begin
        s0_r.mode <= MODE_CORDIC;
        s0_r.fixed_hdg <= HDG_0;
      end
    end
  end

  // stage 1: b = round(a*2^32/3.6e9) = floor((a*2^32 + 1.8e9)/3.6e9)
  // estimate a*2^32/3.6e9 as (a*K) >> 30 with K = floor(2^62/3.6e9);
  // the estimate is at most two below b
  side_t s1_r;
  logic [63:0] prod1_r;
  logic [30:0] alat1_r;
  localparam logic [30:0] KREC = 31'd1281023894;   // floor(2^62/3.6e9)
  always_ff @(posedge clk) begin
    if (!rst_n) s1_r.vld <= 1'b0;
    else if (en) s1_r.vld <= s0_r.vld;
    if (en) begin
      s1_r.mode <= s0_r.mode; s1_r.fixed_hdg <= s0_r.fixed_hdg;
      s1_r.dlat <= s0_r.dlat; s1_r.dlon <= s0_r.dlon; s1_r.neg <= 1'b0;
      prod1_r <= 64'(alat_r) * 64'(KREC);
      alat1_r <= alat_r;
    end
  end

  // stage 2: quotient estimate, then up to two steps of correction by remainder
  side_t s2_r;
  logic [31:0] b_r;
  logic [31:0] qe;
  logic [63:0] num, rem;
  always_comb begin
    qe  = 32'(prod1_r >> 30);
    num = {1'b0, alat1_r, 32'd0} + 64'd1800000000;
    rem = num - 64'(qe) * 64'd3600000000;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s2_r.vld <= 1'b0;
    else if (en) s2_r.vld <= s1_r.vld;
    if (en) begin
      s2_r.mode <= s1_r.mode; s2_r.fixed_hdg <= s1_r.fixed_hdg;
      s2_r.dlat <= s1_r.dlat; s2_r.dlon <= s1_r.dlon;
      if (rem >= 64'd7200000000) b_r <= qe + 32'd2;
      else if (rem >= 64'd3600000000) b_r <= qe + 32'd1;
      else b_r <= qe;
      s2_r.neg <= 1'b0;
    end
  end

  // stage 3: fold into first quadrant
  side_t s3_r;
  logic [31:0] bf_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s3_r.vld <= 1'b0;
    else if (en) s3_r.vld <= s2_r.vld;
    if (en) begin
      s3_r.mode <= s2_r.mode; s3_r.fixed_hdg <= s2_r.fixed_hdg;
      s3_r.dlat <= s2_r.dlat; s3_r.dlon <= s2_r.dlon;
      if (b_r > 32'd1073741824) begin
        bf_r <= 32'd2147483648 - b_r; s3_r.neg <= 1'b1;
      end else begin
        bf_r <= b_r; s3_r.neg <= 1'b0;
      end
    end
  end

  // cosine chain
  side_t rs [NSTAGES+1];
  logic signed [CW-1:0] rx [NSTAGES+1];
  logic signed [CW-1:0] ry [NSTAGES+1];
  logic signed [AW-1:0] rz [NSTAGES+1];
  assign rs[0] = s3_r;
  assign rx[0] = INV_GAIN_Q30;
  assign ry[0] = '0;
  assign rz[0] = AW'($signed({1'b0, bf_r}));

  for (genvar g = 0; g < NSTAGES; g++) begin : g_rot
    side_t so;
    gbc_rot_cell #(.IDX(g)) u_cell (
      .clk(clk), .en(en), .side_i(rs[g]), .x_i(rx[g]), .y_i(ry[g]), .z_i(rz[g]),
      .side_o(so), .x_o(rx[g+1]), .y_o(ry[g+1]), .z_o(rz[g+1])
    );
    logic v_r;
    always_ff @(posedge clk) begin
      if (!rst_n) v_r <= 1'b0;
      else if (en) v_r <= rs[g].vld;
    end
    always_comb begin
      rs[g+1] = so;
      rs[g+1].vld = v_r;
    end
  end

  // stage M: tx = floor(c*dlon/16), ty = dlat<<26
  side_t sm_r;
  logic signed [CW-1:0] c;
  logic signed [VW-1:0] tx_r, ty_r;
  assign c = rs[NSTAGES].neg ? -rx[NSTAGES] : rx[NSTAGES];
  always_ff @(posedge clk) begin
    if (!rst_n) sm_r.vld <= 1'b0;
    else if (en) sm_r.vld <= rs[NSTAGES].vld;
    if (en) begin
      sm_r.mode <= rs[NSTAGES].mode; sm_r.fixed_hdg <= rs[NSTAGES].fixed_hdg;
      sm_r.dlat <= rs[NSTAGES].dlat; sm_r.dlon <= rs[NSTAGES].dlon;
      sm_r.neg <= rs[NSTAGES].neg;
      tx_r <= (VW'(c) * VW'(rs[NSTAGES].dlon)) >>> 4;
      ty_r <= VW'(rs[NSTAGES].dlat) <<< 26;
    end
  end

  // stage N: quadrant pre-rotation
  side_t sn_r;
  logic signed [VW-1:0] vx0_r, vy0_r;
  logic [ZW-1:0] vz0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) sn_r.vld <= 1'b0;
    else if (en) sn_r.vld <= sm_r.vld;
    if (en) begin
      sn_r.mode <= sm_r.mode; sn_r.fixed_hdg <= sm_r.fixed_hdg;
      sn_r.dlat <= sm_r.dlat; sn_r.dlon <= sm_r.dlon; sn_r.neg <= sm_r.neg;
      if (ty_r < 0) begin
        vx0_r <= -ty_r; vy0_r <= -tx_r; vz0_r <= 32'h8000_0000;
      end else begin
        vx0_r <= ty_r; vy0_r <= tx_r; vz0_r <= '0;
      end
    end
  end

  side_t vs [NSTAGES+1];
  logic signed [VW-1:0] vx [NSTAGES+1];
  logic signed [VW-1:0] vy [NSTAGES+1];
  logic [ZW-1:0] vz [NSTAGES+1];
  assign vs[0] = sn_r;
  assign vx[0] = vx0_r;
  assign vy[0] = vy0_r;
  assign vz[0] = vz0_r;

  for (genvar g = 0; g < NSTAGES; g++) begin : g_vec
    side_t so;
    gbc_vec_cell #(.IDX(g)) u_cell (
      .clk(clk), .en(en), .side_i(vs[g]), .x_i(vx[g]), .y_i(vy[g]), .z_i(vz[g]),
      .side_o(so), .x_o(vx[g+1]), .y_o(vy[g+1]), .z_o(vz[g+1])
    );
    logic v_r;
    always_ff @(posedge clk) begin
      if (!rst_n) v_r <= 1'b0;
      else if (en) v_r <= vs[g].vld;
    end
    always_comb begin
      vs[g+1] = so;
      vs[g+1].vld = v_r;
    end
  end

  // stage S: angle*360
  side_t ss_r;
  logic [40:0] sc_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ss_r.vld <= 1'b0;
    else if (en) ss_r.vld <= vs[NSTAGES].vld;
    if (en) begin
      ss_r.mode <= vs[NSTAGES].mode; ss_r.fixed_hdg <= vs[NSTAGES].fixed_hdg;
      ss_r.dlat <= vs[NSTAGES].dlat; ss_r.dlon <= vs[NSTAGES].dlon;
      ss_r.neg <= vs[NSTAGES].neg;
      sc_r <= 41'(vz[NSTAGES]) * 41'd360 + 41'd32768;
    end
  end

  // output register
  logic [HW-1:0] h;
  always_comb begin
    if (ss_r.mode == MODE_FIXED) h = ss_r.fixed_hdg;
    else if (sc_r[40:16] >= HDG_360) h = HDG_0;
    else h = sc_r[40:16];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (en) out_valid <= ss_r.vld;
    if (en) out_heading <= h;
  end
endmodule
`default_nettype wire

// File: rtl/gbc_rot_cell.sv
// One rotation-mode CORDIC stage for the latitude cosine.
`timescale 1ns / 1ps
`default_nettype none
module gbc_rot_cell import gbc_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire side_t                side_i,
  input  wire logic signed [CW-1:0] x_i,
  input  wire logic signed [CW-1:0] y_i,
  input  wire logic signed [AW-1:0] z_i,
  output side_t                     side_o,
  output logic signed [CW-1:0]      x_o,
  output logic signed [CW-1:0]      y_o,
  output logic signed [AW-1:0]      z_o
);
  logic signed [CW-1:0] x_nxt, y_nxt;
  logic signed [AW-1:0] z_nxt, a;

  always_comb begin
    a = AW'($signed({1'b0, arc(6'(IDX))}));
    if (!z_i[AW-1]) begin
      x_nxt = x_i - (y_i >>> IDX);
      y_nxt = y_i + (x_i >>> IDX);
      z_nxt = z_i - a;
    end else begin
      x_nxt = x_i + (y_i >>> IDX);
      y_nxt = y_i - (x_i >>> IDX);
      z_nxt = z_i + a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_o <= side_i;
      x_o <= x_nxt;
      y_o <= y_nxt;
      z_o <= z_nxt;
    end
  end
endmodule
`default_nettype wire

// File: rtl/gbc_vec_cell.sv
// One vectoring-mode CORDIC stage for atan2.
`timescale 1ns / 1ps
`default_nettype none
module gbc_vec_cell import gbc_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire side_t                side_i,
  input  wire logic signed [VW-1:0] x_i,
  input  wire logic signed [VW-1:0] y_i,
  input  wire logic [ZW-1:0]        z_i,
  output side_t                     side_o,
  output logic signed [VW-1:0]      x_o,
  output logic signed [VW-1:0]      y_o,
  output logic [ZW-1:0]             z_o
);
  logic signed [VW-1:0] x_nxt, y_nxt;
  logic [ZW-1:0] z_nxt;

  always_comb begin
    if (y_i > 0) begin
      x_nxt = x_i + (y_i >>> IDX);
      y_nxt = y_i - (x_i >>> IDX);
      z_nxt = z_i + arc(6'(IDX));
    end else begin
      x_nxt = x_i - (y_i >>> IDX);
      y_nxt = y_i + (x_i >>> IDX);
      z_nxt = z_i - arc(6'(IDX));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_o <= side_i;
      x_o <= x_nxt;
      y_o <= y_nxt;
      z_o <= z_nxt;
    end
  end
endmodule
`default_nettype wire

// File: rtl/gbc_checker.sv
// Port-level checks for the bearing unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module gbc_checker import gbc_pkg::*; (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire logic [HW-1:0] out_heading
);
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_heading < HDG_360) else $error("heading out of range");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_heading))
    else $error("result dropped under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("stalled with empty output");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");
endmodule

bind gps_bearing_calculator gbc_checker u_gbc_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_heading(out_heading)
);
`default_nettype wire
